// ===== rtl/jcfc_pkg.sv =====
// shared package: phases, request and status codes, sequencer constants
// no dependencies
`default_nettype none
package jcfc_pkg;
   localparam int MaxDevices = 5;
   localparam int IrBits     = 10;
   localparam int ProbeBits  = 8 + MaxDevices;

   typedef enum logic [2:0] {
      REQ_TICK = 3'd0, REQ_START = 3'd1, REQ_DATA = 3'd2, REQ_END = 3'd3, REQ_COUNT = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_BUSY = 3'd1, ST_BROKEN = 3'd2, ST_BAD_INDEX = 3'd3,
      ST_BAD_ID = 3'd4, ST_NONE = 3'd5
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_PR_NAV, PH_PR_LOAD, PH_PR_TODR, PH_PR_ZERO, PH_PR_CAP,
      PH_ID_NAV, PH_ID_READ, PH_PG_NAV, PH_PG_LOAD, PH_PG_TODR, PH_PG_ONES,
      PH_EN_FLUSH, PH_EN_EXIT, PH_EN_LOAD, PH_EN_IDLE, PH_EN_CLK, PH_EN_RST,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      CSR_PRE_OLDER = 2'd0, CSR_PRE_NEWER = 2'd1, CSR_STARTUP = 2'd2, CSR_SKIP = 2'd3
   } csr_index_type;

   localparam logic [IrBits-1:0] CmdProgram = IrBits'(12'h002);
   localparam logic [IrBits-1:0] CmdStartup = IrBits'(12'h003);
   localparam logic [IrBits-1:0] CmdBypass  = '1;
   localparam logic [15:0] ProbePattern = 16'h0073;
   localparam logic [31:0] IdMask  = 32'hFFF00FFF;
   localparam logic [31:0] IdMatch = 32'h020000DD;
   localparam logic [7:0]  FamOlder = 8'hB0;
   localparam logic [7:0]  FamNewer = 8'hF0;
   localparam logic [7:0]  NavIrTms = 8'hDF;
   localparam logic [7:0]  NavDrTms = 8'h5F;
   localparam logic [7:0]  ExitTms  = 8'h33;
   localparam logic [7:0]  ExitTdi  = 8'h01;

   // queued request as classified by the front end
   typedef struct packed {
      req_code_type code;
      logic [2:0]   dev_index;
      logic [7:0]   data_byte;
      logic         tdo_in;
   } cmd_type;

   typedef struct packed {
      logic        tck_pulse;
      logic        tms_out;
      logic        tdi_out;
      logic        busy_res;
      logic        accepted;
      logic        done_res;
      logic [2:0]  status;
      logic [2:0]  device_count;
      logic [31:0] device_id;
      logic        newer_family;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/jcfc_if.sv =====
// valid/ready channel interfaces for requests, responses and register writes
// depends on jcfc_pkg
`default_nettype none
interface jcfc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [2:0] dev_index;
   logic [7:0] data_byte;
   logic       tdo_in;
   modport source (output valid, req_type, dev_index, data_byte, tdo_in, input ready);
   modport sink (input valid, req_type, dev_index, data_byte, tdo_in, output ready);
endinterface

interface jcfc_rsp_if;
   logic              valid;
   logic              ready;
   jcfc_pkg::rsp_type payload;
   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface

interface jcfc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/jcfc_front.sv =====
// front end: takes request beats, classifies them, feeds a two-entry queue
// depends on jcfc_pkg
`default_nettype none
module jcfc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [2:0]        in_type,
   input  wire logic [2:0]        in_dev,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_tdo,
   output logic                   q_valid,
   input  wire logic              q_pop,
   output jcfc_pkg::cmd_type      q_head
);
   jcfc_pkg::cmd_type q_ff [2];
   jcfc_pkg::cmd_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   jcfc_pkg::cmd_type cls;
   logic push;

   // classify; reserved codes pass through and are ignored by the back end
   always_comb begin
      cls.dev_index = in_dev;
      cls.data_byte = in_byte;
      cls.tdo_in    = in_tdo;
      cls.code      = jcfc_pkg::req_code_type'(in_type);
   end

   assign in_ready = (cnt_ff != 2'd2) || q_pop;
   assign push     = in_valid && in_ready;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_head   = q_ff[0];

   // queue shift
   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (q_pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = cls;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/jcfc_back.sv =====
// back end: jtag sequencer, one result beat per queued request
// depends on jcfc_pkg
`default_nettype none
module jcfc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire jcfc_pkg::cmd_type q_head,
   input  wire logic [15:0]       pre_older,
   input  wire logic [15:0]       pre_newer,
   input  wire logic [15:0]       start_clks,
   input  wire logic [5:0]        skip_bytes,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output jcfc_pkg::rsp_type      out_data
);
   localparam int ProbeLoad = jcfc_pkg::MaxDevices * jcfc_pkg::IrBits + 1;
   localparam int ProbeZero = jcfc_pkg::MaxDevices * 32;

   jcfc_pkg::phase_type phase_ff, phase_in;
   logic [15:0] step_ff, step_in;
   logic [2:0]  chain_ff, chain_in, tgt_ff, tgt_in;
   logic [31:0] id_ff, id_in;
   logic [jcfc_pkg::ProbeBits-1:0] cap_ff, cap_in;
   logic [7:0]  byte_ff, byte_in;
   logic [5:0]  seen_ff, seen_in;
   logic        fam_ff, fam_in, pfs_ff, pfs_in;
   // instruction load bit tracking: bit within device, device position
   logic [3:0]  irb_ff, irb_in;
   logic [2:0]  dpos_ff, dpos_in;
   logic        ov_ff;
   jcfc_pkg::rsp_type od_ff, r;
   logic        go;

   // phase length for any phase using the current state
   function automatic logic [15:0] plen(jcfc_pkg::phase_type p, logic [2:0] cl, logic [2:0] ti,
                                        logic fm, logic [15:0] po, logic [15:0] pn,
                                        logic [15:0] sc);
      logic [15:0] v;
      unique case (p)
         jcfc_pkg::PH_PR_NAV, jcfc_pkg::PH_PG_NAV: v = 16'd10;
         jcfc_pkg::PH_PR_LOAD: v = 16'(ProbeLoad);
         jcfc_pkg::PH_PR_TODR, jcfc_pkg::PH_PG_TODR: v = 16'd3;
         jcfc_pkg::PH_PR_ZERO: v = 16'(ProbeZero);
         jcfc_pkg::PH_PR_CAP: v = 16'(jcfc_pkg::ProbeBits);
         jcfc_pkg::PH_ID_NAV: v = 16'd9;
         jcfc_pkg::PH_ID_READ: v = (ti < cl) ? {8'd0, 3'(cl - ti), 5'd0} : 16'd0;
         jcfc_pkg::PH_PG_LOAD, jcfc_pkg::PH_EN_LOAD:
            v = 16'(cl * 16'(jcfc_pkg::IrBits)) + 16'd1;
         jcfc_pkg::PH_PG_ONES: v = fm ? pn : po;
         jcfc_pkg::PH_EN_FLUSH: v = 16'd128;
         jcfc_pkg::PH_EN_EXIT: v = 16'd8;
         jcfc_pkg::PH_EN_IDLE: v = 16'd1;
         jcfc_pkg::PH_EN_CLK: v = sc;
         jcfc_pkg::PH_EN_RST: v = 16'd5;
         jcfc_pkg::PH_DATA: v = 16'd8;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // next phase, skipping empty stretches (only ones, startup clocks can be empty)
   function automatic jcfc_pkg::phase_type adv(jcfc_pkg::phase_type p, logic fm,
                                               logic [15:0] po, logic [15:0] pn,
                                               logic [15:0] sc);
      jcfc_pkg::phase_type n;
      priority case (p)
         jcfc_pkg::PH_PG_TODR: n = ((fm ? pn : po) == 16'd0) ? jcfc_pkg::PH_IDLE
                                                             : jcfc_pkg::PH_PG_ONES;
         jcfc_pkg::PH_EN_IDLE: n = (sc == 16'd0) ? jcfc_pkg::PH_EN_RST : jcfc_pkg::PH_EN_CLK;
         jcfc_pkg::PH_ID_READ: n = jcfc_pkg::PH_PG_NAV;
         jcfc_pkg::PH_PR_CAP, jcfc_pkg::PH_PG_ONES, jcfc_pkg::PH_EN_RST, jcfc_pkg::PH_DATA,
         jcfc_pkg::PH_IDLE: n = jcfc_pkg::PH_IDLE;
         default: n = jcfc_pkg::phase_type'(5'(p) + 5'd1);
      endcase
      return n;
   endfunction

   assign go    = q_valid && (!ov_ff || out_ready);
   assign q_pop = go;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;

   // sequencer step
   always_comb begin
      logic [15:0] k, len, ir_sel;
      logic        fin, in_tot, last_bit, sel;
      logic [2:0]  cnt, lcnt;
      logic        found;
      logic [7:0]  fam;
      logic [jcfc_pkg::IrBits-1:0] cmd;
      jcfc_pkg::phase_type np;
      phase_in = phase_ff; step_in = step_ff; chain_in = chain_ff; tgt_in = tgt_ff;
      id_in = id_ff; cap_in = cap_ff; byte_in = byte_ff; seen_in = seen_ff;
      fam_in = fam_ff; pfs_in = pfs_ff; irb_in = irb_ff; dpos_in = dpos_ff;
      r = '0;
      r.status = jcfc_pkg::ST_NONE;
      k = step_ff; fin = 1'b0; in_tot = 1'b0; last_bit = 1'b0; sel = 1'b0;
      cnt = 3'd0; found = 1'b0; fam = 8'd0; cmd = '0; np = jcfc_pkg::PH_IDLE;
      lcnt = 3'd0; len = 16'd0; ir_sel = 16'd0;
      if (q_head.code == jcfc_pkg::REQ_TICK) begin
         if (phase_ff != jcfc_pkg::PH_IDLE) begin
            r.tck_pulse = 1'b1;
            // instruction load geometry
            lcnt = (phase_ff == jcfc_pkg::PH_PR_LOAD) ? 3'(jcfc_pkg::MaxDevices) : chain_ff;
            ir_sel = 16'(lcnt * 16'(jcfc_pkg::IrBits));
            in_tot = k < ir_sel;
            last_bit = (k + 16'd1 == ir_sel) || (k == ir_sel);
            sel = (phase_ff != jcfc_pkg::PH_PR_LOAD) && (dpos_ff == tgt_ff);
            cmd = (phase_ff == jcfc_pkg::PH_PG_LOAD) ? jcfc_pkg::CmdProgram
                                                     : jcfc_pkg::CmdStartup;
            if (!sel) cmd = jcfc_pkg::CmdBypass;
            priority case (phase_ff)
               jcfc_pkg::PH_PR_NAV, jcfc_pkg::PH_PG_NAV:
                  r.tms_out = jcfc_pkg::NavIrTms[k[2:0]] & ~k[3];
               jcfc_pkg::PH_PR_LOAD, jcfc_pkg::PH_PG_LOAD, jcfc_pkg::PH_EN_LOAD: begin
                  r.tms_out = last_bit;
                  r.tdi_out = in_tot && cmd[irb_ff];
               end
               jcfc_pkg::PH_PR_TODR: r.tms_out = (k == 16'd0);
               jcfc_pkg::PH_PG_TODR: begin
                  r.tms_out = (k == 16'd0);
                  r.tdi_out = 1'b1;
               end
               jcfc_pkg::PH_PR_CAP: begin
                  r.tdi_out = jcfc_pkg::ProbePattern[k[3:0]];
                  cap_in[k[3:0]] = cap_ff[k[3:0]] | q_head.tdo_in;
               end
               jcfc_pkg::PH_ID_NAV: r.tms_out = jcfc_pkg::NavDrTms[k[2:0]] & ~k[3];
               jcfc_pkg::PH_ID_READ: id_in = {q_head.tdo_in, id_ff[31:1]};
               jcfc_pkg::PH_PG_ONES, jcfc_pkg::PH_EN_FLUSH, jcfc_pkg::PH_EN_CLK:
                  r.tdi_out = 1'b1;
               jcfc_pkg::PH_EN_EXIT: begin
                  r.tms_out = jcfc_pkg::ExitTms[k[2:0]];
                  r.tdi_out = jcfc_pkg::ExitTdi[k[2:0]];
               end
               jcfc_pkg::PH_EN_RST: r.tms_out = 1'b1;
               jcfc_pkg::PH_DATA: r.tdi_out = byte_ff[k[2:0]];
               default: r.tms_out = 1'b0;
            endcase
            // advance load-bit counters
            if (irb_ff == 4'(jcfc_pkg::IrBits - 1)) begin
               irb_in = 4'd0;
               dpos_in = dpos_ff - 3'd1;
            end else begin
               irb_in = irb_ff + 4'd1;
            end
            len = plen(phase_ff, chain_ff, tgt_ff, fam_ff, pre_older, pre_newer, start_clks);
            step_in = k + 16'd1;
            if (step_in >= len) begin
               step_in = 16'd0;
               if (phase_ff == jcfc_pkg::PH_PR_CAP) begin
                  for (int i = jcfc_pkg::MaxDevices - 1; i >= 0; i--) begin
                     if (cap_in[i]) begin
                        cnt = 3'(i);
                        found = 1'b1;
                     end
                  end
                  if (!found || (16'(cap_in >> cnt) != jcfc_pkg::ProbePattern)) begin
                     chain_in = 3'd0; fin = 1'b1; r.status = jcfc_pkg::ST_BROKEN;
                  end else begin
                     chain_in = cnt;
                     if (!pfs_ff) begin
                        fin = 1'b1; r.status = jcfc_pkg::ST_OK;
                     end else if (tgt_ff >= cnt) begin
                        fin = 1'b1; r.status = jcfc_pkg::ST_BAD_INDEX;
                     end else begin
                        phase_in = jcfc_pkg::PH_ID_NAV;
                     end
                  end
               end else if (phase_ff == jcfc_pkg::PH_ID_READ) begin
                  fam = id_in[19:12] & 8'hF0;
                  if ((id_in & jcfc_pkg::IdMask) != jcfc_pkg::IdMatch ||
                      (fam != jcfc_pkg::FamOlder && fam != jcfc_pkg::FamNewer)) begin
                     fin = 1'b1; r.status = jcfc_pkg::ST_BAD_ID;
                  end else begin
                     fam_in = (fam == jcfc_pkg::FamNewer);
                     seen_in = 6'd0;
                     phase_in = jcfc_pkg::PH_PG_NAV;
                  end
               end else begin
                  np = adv(phase_ff, fam_ff, pre_older, pre_newer, start_clks);
                  phase_in = np;
                  if (np == jcfc_pkg::PH_IDLE) begin
                     fin = 1'b1; r.status = jcfc_pkg::ST_OK;
                  end
               end
               // ID read follows straight after nav
               if (phase_in == jcfc_pkg::PH_ID_NAV && !fin) phase_in = jcfc_pkg::PH_ID_NAV;
               irb_in = 4'd0;
               dpos_in = chain_ff - 3'd1;
               if (phase_in == jcfc_pkg::PH_PR_LOAD)
                  dpos_in = 3'(jcfc_pkg::MaxDevices - 1);
               if (fin) begin
                  phase_in = jcfc_pkg::PH_IDLE;
                  r.done_res = 1'b1;
               end
            end
         end
      end else if (q_head.code == jcfc_pkg::REQ_START || q_head.code == jcfc_pkg::REQ_DATA ||
                   q_head.code == jcfc_pkg::REQ_END || q_head.code == jcfc_pkg::REQ_COUNT) begin
         if (phase_ff != jcfc_pkg::PH_IDLE) begin
            r.status = jcfc_pkg::ST_BUSY;
         end else begin
            r.accepted = 1'b1;
            r.status = jcfc_pkg::ST_OK;
            step_in = 16'd0;
            irb_in = 4'd0;
            dpos_in = 3'(jcfc_pkg::MaxDevices - 1);
            if (q_head.code == jcfc_pkg::REQ_START || q_head.code == jcfc_pkg::REQ_COUNT) begin
               pfs_in = (q_head.code == jcfc_pkg::REQ_START);
               if (q_head.code == jcfc_pkg::REQ_START) tgt_in = q_head.dev_index;
               cap_in = '0;
               phase_in = jcfc_pkg::PH_PR_NAV;
            end else if (q_head.code == jcfc_pkg::REQ_END) begin
               phase_in = jcfc_pkg::PH_EN_FLUSH;
            end else begin
               byte_in = q_head.data_byte;
               if (seen_ff < skip_bytes) seen_in = seen_ff + 6'd1;
               if (!fam_ff && seen_ff < skip_bytes) r.done_res = 1'b1;
               else phase_in = jcfc_pkg::PH_DATA;
            end
         end
      end
      r.busy_res = phase_in != jcfc_pkg::PH_IDLE;
      r.device_count = chain_in;
      r.device_id = id_in;
      r.newer_family = fam_in;
   end

   always_ff @(posedge clock) begin
      if (go) od_ff <= r;
      if (reset) begin
         ov_ff <= 1'b0;
         phase_ff <= jcfc_pkg::PH_IDLE;
         step_ff <= '0; chain_ff <= '0; tgt_ff <= '0; id_ff <= '0; cap_ff <= '0;
         byte_ff <= '0; seen_ff <= '0; fam_ff <= 1'b0; pfs_ff <= 1'b0;
         irb_ff <= '0; dpos_ff <= '0;
      end else begin
         if (go) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
         if (go) begin
            phase_ff <= phase_in; step_ff <= step_in; chain_ff <= chain_in;
            tgt_ff <= tgt_in; id_ff <= id_in; cap_ff <= cap_in; byte_ff <= byte_in;
            seen_ff <= seen_in; fam_ff <= fam_in; pfs_ff <= pfs_in;
            irb_ff <= irb_in; dpos_ff <= dpos_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/jtag_chain_fpga_configurator.sv =====
// top level: register file, request front end, queue and jtag sequencer
// depends on jcfc_pkg, jcfc_if, jcfc_front, jcfc_back
`default_nettype none
// Each request beat yields one response beat; a tick drives at most one TCK
// pulse and the block takes one beat per clock unless the response is stalled;
// each request passes through the two-entry request queue and the response
// register. Register writes are taken at any time but should only be made
// while no sequence runs.
module jtag_chain_fpga_configurator (
   input wire logic  clock,
   input wire logic  reset,
   jcfc_req_if.sink  req,
   jcfc_rsp_if.source rsp,
   jcfc_csr_if.sink  csr
);
   logic [15:0] pre_older_ff, pre_newer_ff, start_ff;
   logic [5:0]  skip_ff;
   logic        q_valid, q_pop;
   jcfc_pkg::cmd_type q_head;

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_older_ff <= 16'd300;
         pre_newer_ff <= 16'd3181;
         start_ff     <= 16'd200;
         skip_ff      <= 6'd44;
      end else if (csr.valid) begin
         unique case (jcfc_pkg::csr_index_type'(csr.index))
            jcfc_pkg::CSR_PRE_OLDER: pre_older_ff <= csr.data;
            jcfc_pkg::CSR_PRE_NEWER: pre_newer_ff <= csr.data;
            jcfc_pkg::CSR_STARTUP:   start_ff     <= csr.data;
            jcfc_pkg::CSR_SKIP:      skip_ff      <= csr.data[5:0];
            default:                 skip_ff      <= skip_ff;
         endcase
      end
   end

   jcfc_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_type(req.req_type),
      .in_dev(req.dev_index), .in_byte(req.data_byte), .in_tdo(req.tdo_in),
      .q_valid, .q_pop, .q_head
   );

   jcfc_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_head,
      .pre_older(pre_older_ff), .pre_newer(pre_newer_ff), .start_clks(start_ff),
      .skip_bytes(skip_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );
endmodule
`default_nettype wire

// ===== rtl/jcfc_checker.sv =====
// port-level checks on the configurator
// depends on jcfc_pkg, bound to jtag_chain_fpga_configurator
`default_nettype none
module jcfc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire jcfc_pkg::rsp_type rsp_payload
);
   // refused beats report busy
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.accepted && rsp_payload.status == jcfc_pkg::ST_BUSY
      |-> rsp_payload.busy_res) else $error("refused beat while idle");
   // done never claims busy
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res && rsp_payload.tck_pulse |-> !rsp_payload.busy_res)
      else $error("done with busy");
   // no pulse, no levels
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.tck_pulse |-> !rsp_payload.tms_out && !rsp_payload.tdi_out)
      else $error("levels without pulse");
   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped");
endmodule

bind jtag_chain_fpga_configurator jcfc_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
`default_nettype wire
